// File: design/sewr_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// sewr_pkg
// Shared types and constants for the serial EEPROM word reader.
// ============================================================================
package sewr_pkg;

    // Pin levels, bit 0 = clock, bit 1 = select, bit 2 = data in
    typedef logic [2:0] t_pins;

    localparam t_pins PIN_NONE = 3'b000;
    localparam t_pins PIN_C    = 3'b001;
    localparam t_pins PIN_S    = 3'b010;
    localparam t_pins PIN_D    = 3'b100;

    localparam int ADDR_LATCH_BITS = 8;
    localparam int WORD_BITS       = 16;
    localparam int HEAD_STEPS      = 10;
    localparam int TAIL_STEPS      = 4;

    localparam t_pins HEAD_LEVELS [HEAD_STEPS] = '{
        PIN_NONE, PIN_S, PIN_S | PIN_C, PIN_S,
        PIN_S | PIN_D, PIN_S | PIN_D | PIN_C,
        PIN_S | PIN_D, PIN_S | PIN_D | PIN_C,
        PIN_S, PIN_S | PIN_C
    };

    localparam t_pins TAIL_LEVELS [TAIL_STEPS] = '{PIN_NONE, PIN_S, PIN_NONE, PIN_C};

    typedef enum logic {
        KIND_TICK  = 1'b0,
        KIND_START = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                      kind;
        logic [ADDR_LATCH_BITS-1:0] addr;
        logic                       dout;
    } t_item;

    typedef struct packed {
        logic [WORD_BITS-1:0] word;
        logic                 done;
        logic                 busy;
        t_pins                pins;
    } t_result;

endpackage

// File: design/sewr_levels.sv
`timescale 1ns / 1ps
// ============================================================================
// sewr_levels
// Pin levels driven for one step of the read sequence.
// ============================================================================
module sewr_levels #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16,
    localparam int ADDR_FIRST = sewr_pkg::HEAD_STEPS,
    localparam int SEL_STEP   = ADDR_FIRST + 2 * ADDR_BITS,
    localparam int DATA_FIRST = SEL_STEP + 1,
    localparam int TAIL_FIRST = DATA_FIRST + 2 * DATA_BITS,
    localparam int LAST_STEP  = TAIL_FIRST + 3,
    localparam int SW         = $clog2(LAST_STEP + 1),
    localparam int AIW        = $clog2(ADDR_BITS)
) (
    input  logic [SW-1:0]                        i_step,
    input  logic [sewr_pkg::ADDR_LATCH_BITS-1:0] i_addr,
    output sewr_pkg::t_pins                      o_pins
);

    logic [SW-1:0]  addr_off;
    logic [SW-1:0]  data_off;
    logic [SW-1:0]  tail_off;
    logic [AIW-1:0] bit_sel;
    logic           addr_bit;

    assign addr_off = i_step - SW'(ADDR_FIRST);
    assign data_off = i_step - SW'(DATA_FIRST);
    assign tail_off = i_step - SW'(TAIL_FIRST);
    assign bit_sel  = AIW'(ADDR_BITS - 1) - AIW'(addr_off[SW-1:1]);
    assign addr_bit = ({1'b0, bit_sel} < (AIW + 1)'(sewr_pkg::ADDR_LATCH_BITS))
                      ? i_addr[bit_sel[2:0]] : 1'b0;

    always_comb begin
        if (i_step < SW'(ADDR_FIRST)) begin
            o_pins = sewr_pkg::HEAD_LEVELS[i_step[3:0]];
        end else if (i_step < SW'(SEL_STEP)) begin
            o_pins = sewr_pkg::PIN_S
                   | (addr_bit ? sewr_pkg::PIN_D : sewr_pkg::PIN_NONE)
                   | (addr_off[0] ? sewr_pkg::PIN_C : sewr_pkg::PIN_NONE);
        end else if (i_step == SW'(SEL_STEP)) begin
            o_pins = sewr_pkg::PIN_S;
        end else if (i_step < SW'(TAIL_FIRST)) begin
            o_pins = data_off[0] ? sewr_pkg::PIN_S : (sewr_pkg::PIN_S | sewr_pkg::PIN_C);
        end else if (i_step <= SW'(LAST_STEP)) begin
            o_pins = sewr_pkg::TAIL_LEVELS[tail_off[1:0]];
        end else begin
            o_pins = sewr_pkg::PIN_NONE;
        end
    end

endmodule

// File: design/sewr_core.sv
`timescale 1ns / 1ps
// ============================================================================
// sewr_core
// Sequence state, data shift-in and the registered result stage.
// ============================================================================
module sewr_core #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16,
    localparam int ADDR_FIRST = sewr_pkg::HEAD_STEPS,
    localparam int SEL_STEP   = ADDR_FIRST + 2 * ADDR_BITS,
    localparam int DATA_FIRST = SEL_STEP + 1,
    localparam int TAIL_FIRST = DATA_FIRST + 2 * DATA_BITS,
    localparam int LAST_STEP  = TAIL_FIRST + 3,
    localparam int SW         = $clog2(LAST_STEP + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  sewr_pkg::t_item   i_item,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_ready,
    output sewr_pkg::t_result o_result
);

    logic [SW-1:0]                        r_step,   n_step;
    logic [sewr_pkg::ADDR_LATCH_BITS-1:0] r_addr,   n_addr;
    logic [DATA_BITS-1:0]                 r_data,   n_data;
    logic                                 r_active, n_active;
    sewr_pkg::t_pins                      r_last,   n_last;
    logic                                 r_valid,  n_valid;
    sewr_pkg::t_result                    r_result, n_result;

    sewr_pkg::t_pins step_pins;
    logic [SW-1:0]   data_off;
    logic            take;
    logic            sample;

    sewr_levels #(
        .ADDR_BITS(ADDR_BITS),
        .DATA_BITS(DATA_BITS)
    ) u_levels (
        .i_step(r_step),
        .i_addr(r_addr),
        .o_pins(step_pins)
    );

    assign o_ready  = !r_valid || i_ready;
    assign take     = i_valid && o_ready;
    assign data_off = r_step - SW'(DATA_FIRST);
    assign sample   = (r_step >= SW'(DATA_FIRST + 2)) && (r_step <= SW'(TAIL_FIRST))
                      && !data_off[0];

    always_comb begin
        n_step   = r_step;
        n_addr   = r_addr;
        n_data   = r_data;
        n_active = r_active;
        n_last   = r_last;
        n_result = r_result;
        n_valid  = r_valid && !i_ready;
        if (take) begin
            n_valid       = 1'b1;
            n_result.pins = sewr_pkg::PIN_NONE;
            n_result.busy = 1'b0;
            n_result.done = 1'b0;
            n_result.word = '0;
            if (i_item.kind == sewr_pkg::KIND_START) begin
                n_result.busy = 1'b1;
                if (r_active) begin
                    n_result.pins = r_last;
                end else begin
                    n_addr   = i_item.addr;
                    n_data   = '0;
                    n_step   = '0;
                    n_active = 1'b1;
                    n_last   = sewr_pkg::PIN_NONE;
                end
            end else if (r_active) begin
                if (sample) begin
                    n_data = {r_data[DATA_BITS-2:0], i_item.dout};
                end
                n_result.pins = step_pins;
                n_last        = step_pins;
                if (r_step >= SW'(LAST_STEP)) begin
                    n_result.done = 1'b1;
                    n_result.word = sewr_pkg::WORD_BITS'(n_data);
                    n_active      = 1'b0;
                    n_step        = '0;
                end else begin
                    n_result.busy = 1'b1;
                    n_step        = r_step + SW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= '0;
            r_addr   <= '0;
            r_data   <= '0;
            r_active <= 1'b0;
            r_last   <= sewr_pkg::PIN_NONE;
            r_valid  <= 1'b0;
        end else begin
            r_step   <= n_step;
            r_addr   <= n_addr;
            r_data   <= n_data;
            r_active <= n_active;
            r_last   <= n_last;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// File: design/serial_eeprom_word_reader_top.sv
`timescale 1ns / 1ps
// ============================================================================
// serial_eeprom_word_reader_top
// Microwire-style serial EEPROM read master, one pin step per transaction.
// ============================================================================
// Takes one transaction per clock unless m_tready back-pressure stalls it,
// and returns one result per transaction via the input register and then the
// result register. A start transaction (tuser = 1) latches the word address;
// each following tick transaction (tuser = 0) returns the clock, select and
// data-in levels of the next step and samples the EEPROM data output where a
// data bit is due. The final tick of the 15 + 2*ADDR_BITS + 2*DATA_BITS step
// sequence carries tlast with the assembled word. A start during a running
// sequence is ignored and repeats the last driven pin levels.
module serial_eeprom_word_reader_top #(
    parameter int ADDR_BITS = 8,
    parameter int DATA_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // word_address[7:0], data_out_pin[8], zero fill
    input  logic        i_s_tuser,   // kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // clock_pin, select_pin, data_in_pin, busy_res,
                                     // read_word[19:4], zero fill
    output logic        o_m_tlast    // done_res
);

    logic              r_in_valid, n_in_valid;
    sewr_pkg::t_item   r_in_item;
    sewr_pkg::t_item   s_item;
    sewr_pkg::t_result result;
    logic              core_ready;
    logic              advance;
    logic              s_take;

    assign s_item.kind = sewr_pkg::t_kind'(i_s_tuser);
    assign s_item.addr = i_s_tdata[7:0];
    assign s_item.dout = i_s_tdata[8];

    assign advance    = r_in_valid && core_ready;
    assign o_s_tready = !r_in_valid || core_ready;
    assign s_take     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (s_take) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_item <= s_item;
        end
    end

    sewr_core #(
        .ADDR_BITS(ADDR_BITS),
        .DATA_BITS(DATA_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .i_item  (r_in_item),
        .o_ready (core_ready),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_result(result)
    );

    assign o_m_tdata = {4'b0000, result.word, result.busy, result.pins};
    assign o_m_tlast = result.done;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> !o_m_tdata[3])
        else $error("done result still reports busy");

    a_done_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tdata[2:0] == sewr_pkg::PIN_C)
        else $error("done result does not drive the final step");

    a_word_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tdata[19:4] == 16'h0000)
        else $error("word reported outside the done result");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !core_ready |=> r_in_valid && $stable(r_in_item))
        else $error("input register lost a waiting transaction");

endmodule
